>>> rtl/kvfm_pkg.sv
package kvfm_pkg;

   localparam int NUM_KEYS     = 4;
   localparam int KEY_BYTES    = 8;
   localparam int LENGTH_BITS  = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int POS_SEL_BITS = $clog2(KEY_BYTES);

   localparam logic [7:0] DELIM_CHAR   = 8'h3A;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   localparam logic [2:0] CSR_KEY_LENGTHS = 3'd4;
   localparam logic [2:0] CSR_KEY_COUNT   = 3'd5;

   localparam logic [NUM_KEYS-1:0] ALIVE_RESET = NUM_KEYS'(1);
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

   typedef enum logic [2:0] {
      ST_NONE       = 3'd0,
      ST_MATCHED    = 3'd1,
      ST_NO_MATCH   = 3'd2,
      ST_VALUE_BYTE = 3'd3,
      ST_VALUE_DONE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_NAME  = 3'b001,
      PH_VALUE = 3'b010,
      PH_WAIT  = 3'b100
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic       is_delim;
      logic       is_newline;
   } item_type;

   typedef struct packed {
      logic [NUM_KEYS-1:0][63:0] key_word;
      logic [15:0]               key_lengths;
      logic [2:0]                key_count;
   } cfg_type;

endpackage

>>> rtl/key_value_field_matcher_core.sv
// Key/value field matcher.
// Request channel (req_valid/req_ready): one text byte per request, req_kind 0,
// or req_kind 1 for end of input, which also restarts matching for the next line.
// Response channel (rsp_valid/rsp_ready): exactly one response per request, in
// order, carrying status (nothing, key matched, no match, value byte, value done)
// with the key index, value byte or saturating value length.
// Keys are set through the csr_ write port (index 0..3 key names, 4 packed name
// lengths, 5 key count); writes take effect on the next edge. The user must write
// only while no request is in flight; the block itself does not enforce this.
// A request is queued, then moves into the response register once that is free.
// Throughput: one request per cycle while responses are taken; the per-key compares
// run in parallel in the execute stage, which decides one byte per unstalled cycle.
// A four-entry queue sits between the request classifier and the execute stage,
// with a response register after it; when the receiver stalls, the queue fills and
// req_ready drops once it holds four requests.
// Reset clears the queue, drops rsp_valid, loads the register reset values and
// starts in the name phase with key 0 alive.
module key_value_field_matcher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_key_index,
   output logic [7:0]  rsp_value_byte,
   output logic [15:0] rsp_value_length,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   import kvfm_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     pop;
   logic     q_valid;
   item_type q_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         priority if (csr_index < 3'(NUM_KEYS)) begin
            cfg_in.key_word[csr_index[1:0]] = csr_write_data;
         end else if (csr_index == CSR_KEY_LENGTHS) begin
            cfg_in.key_lengths = csr_write_data[15:0];
         end else if (csr_index == CSR_KEY_COUNT) begin
            cfg_in.key_count = csr_write_data[2:0];
         end else begin
            cfg_in = cfg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_word    <= '0;
         cfg_ff.key_lengths <= '0;
         cfg_ff.key_count   <= 3'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kvfm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .pop            (pop),
      .q_valid        (q_valid),
      .q_item         (q_item)
   );

   kvfm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_key_index    (rsp_key_index),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_value_length (rsp_value_length)
   );

endmodule

>>> rtl/kvfm_front.sv
module kvfm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [7:0]         req_byte_value,
   input  logic               pop,
   output logic               q_valid,
   output kvfm_pkg::item_type q_item
);
   import kvfm_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   item_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   item_type              new_item;
   logic                  push;

   assign req_ready = (count_ff != COUNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      new_item.kind       = req_kind;
      new_item.byte_value = req_byte_value;
      new_item.is_delim   = (req_byte_value == DELIM_CHAR);
      new_item.is_newline = (req_byte_value == NEWLINE_CHAR);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> rtl/kvfm_back.sv
module kvfm_back (
   input  logic               clock,
   input  logic               reset,
   input  kvfm_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  kvfm_pkg::item_type q_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [1:0]         rsp_key_index,
   output logic [7:0]         rsp_value_byte,
   output logic [15:0]        rsp_value_length
);
   import kvfm_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [3:0]             pos_ff, pos_in;
   logic [NUM_KEYS-1:0]    alive_ff, alive_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, status_in;
   logic [1:0]             rsp_key_index_ff, kidx_in;
   logic [7:0]             rsp_value_byte_ff, vbyte_in;
   logic [15:0]            rsp_value_length_ff, vlen_in;

   logic [2:0]             keys_used;
   logic [NUM_KEYS-1:0]    use_mask;
   logic [NUM_KEYS-1:0]    hit;
   logic [NUM_KEYS-1:0]    fail;
   logic [1:0]             hit_index;
   logic                   fire;

   assign fire = q_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = fire;

   assign keys_used = (cfg.key_count > 3'd4) ? 3'd4 : cfg.key_count;

   always_comb begin
      logic [3:0] nib;
      logic [3:0] len;
      logic [7:0] nb;
      logic       past;
      use_mask  = '0;
      hit       = '0;
      fail      = '0;
      hit_index = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         nib         = cfg.key_lengths[4*k +: 4];
         len         = (nib > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : nib;
         nb          = cfg.key_word[k][8*pos_ff[POS_SEL_BITS-1:0] +: 8];
         past        = (pos_ff >= len);
         use_mask[k] = (4'(k) < 4'(keys_used));
         hit[k]      = use_mask[k] && alive_ff[k] && past && q_item.is_delim;
         fail[k]     = past ? !q_item.is_delim : (nb != q_item.byte_value);
      end
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            hit_index = 2'(k);
         end
      end
   end

   always_comb begin
      logic [NUM_KEYS-1:0] alive_next;
      alive_next = alive_ff & ~fail & use_mask;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      alive_in   = alive_ff;
      count_in   = count_ff;
      status_in  = ST_NONE;
      kidx_in    = '0;
      vbyte_in   = '0;
      vlen_in    = '0;
      if (q_item.kind) begin
         unique case (phase_ff)
            PH_NAME: begin
               status_in = ST_NO_MATCH;
            end
            PH_VALUE: begin
               status_in = ST_VALUE_DONE;
               vlen_in   = 16'(count_ff);
            end
            default: begin
               status_in = ST_NONE;
            end
         endcase
         phase_in = PH_NAME;
         pos_in   = '0;
         alive_in = use_mask;
         count_in = '0;
      end else begin
         unique case (phase_ff)
            PH_NAME: begin
               if (|hit) begin
                  status_in = ST_MATCHED;
                  kidx_in   = hit_index;
                  phase_in  = PH_VALUE;
                  count_in  = '0;
               end else begin
                  alive_in = alive_next;
                  if (alive_next == '0) begin
                     status_in = ST_NO_MATCH;
                     phase_in  = PH_WAIT;
                  end
                  if (pos_ff != 4'd15) begin
                     pos_in = pos_ff + 4'd1;
                  end
               end
            end
            PH_VALUE: begin
               if (q_item.is_newline) begin
                  status_in = ST_VALUE_DONE;
                  vlen_in   = 16'(count_ff);
                  phase_in  = PH_WAIT;
               end else begin
                  status_in = ST_VALUE_BYTE;
                  vbyte_in  = q_item.byte_value;
                  if (count_ff != LENGTH_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            default: begin
               status_in = ST_NONE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NAME;
         pos_ff       <= '0;
         alive_ff     <= ALIVE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            alive_ff <= alive_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff       <= status_in;
         rsp_key_index_ff    <= kidx_in;
         rsp_value_byte_ff   <= vbyte_in;
         rsp_value_length_ff <= vlen_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_key_index    = rsp_key_index_ff;
   assign rsp_value_byte   = rsp_value_byte_ff;
   assign rsp_value_length = rsp_value_length_ff;

   a_match_enters_value: assert property (@(posedge clock) disable iff (reset)
      fire && !q_item.kind && phase_ff == PH_NAME && (|hit) |=>
         phase_ff == PH_VALUE && count_ff == '0)
      else $error("match did not enter value phase");

   a_wait_is_silent: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_WAIT |=> rsp_valid_ff && rsp_status_ff == ST_NONE)
      else $error("report while waiting for restart");

   a_value_byte_counts: assert property (@(posedge clock) disable iff (reset)
      fire && !q_item.kind && phase_ff == PH_VALUE && !q_item.is_newline |=>
         count_ff != '0 && rsp_status_ff == ST_VALUE_BYTE)
      else $error("value byte not counted");

endmodule

>>> dv/key_value_field_matcher_core_test.sv
module key_value_field_matcher_core_test;
   import kvfm_pkg::*;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd0;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 800;

   typedef struct {
      status_type  status;
      logic [1:0]  key_index;
      logic [7:0]  value_byte;
      logic [15:0] value_length;
   } report_type;

   class field_match_tracker;
      logic [63:0] key_word [NUM_KEYS];
      logic [15:0] key_lengths;
      logic [2:0]  key_count;
      phase_type   phase;
      logic [3:0]  name_pos;
      logic [3:0]  alive;
      logic [15:0] value_count;
      report_type  expected_reports [$];
      int          failures;

      function new();
         foreach (key_word[k]) key_word[k] = '0;
         key_lengths = '0;
         key_count = 3'd1;
         failures = 0;
         restart();
      endfunction

      function int keys_in_use();
         return (key_count > 3'd4) ? 4 : int'(key_count);
      endfunction

      function int name_len(int k);
         int len;
         len = int'(key_lengths[4*k +: 4]);
         return (len > KEY_BYTES) ? KEY_BYTES : len;
      endfunction

      function void restart();
         phase = PH_NAME;
         name_pos = '0;
         alive = 4'((1 << keys_in_use()) - 1);
         value_count = '0;
      endfunction

      function void write_register(logic [2:0] idx, logic [63:0] data);
         case (idx)
            CSR_KEY_LENGTHS: key_lengths = data[15:0];
            CSR_KEY_COUNT: key_count = data[2:0];
            default: if (idx < CSR_KEY_LENGTHS) key_word[idx[1:0]] = data;
         endcase
      endfunction

      function void predict_byte(logic kind, logic [7:0] b);
         report_type r;
         int n;
         bit matched;
         r.status = ST_NONE;
         r.key_index = '0;
         r.value_byte = '0;
         r.value_length = '0;
         n = keys_in_use();
         if (kind == KIND_END) begin
            if (phase == PH_NAME) begin
               r.status = ST_NO_MATCH;
            end else if (phase == PH_VALUE) begin
               r.status = ST_VALUE_DONE;
               r.value_length = value_count;
            end
            restart();
         end else if (phase == PH_NAME) begin
            matched = 0;
            for (int k = 0; k < n && !matched; k++) begin
               if (!alive[k]) continue;
               if (name_pos >= name_len(k)) begin
                  if (b == DELIM_CHAR) begin
                     matched = 1;
                     r.key_index = 2'(k);
                  end else begin
                     alive[k] = 1'b0;
                  end
               end else if (key_word[k][8*name_pos[2:0] +: 8] != b) begin
                  alive[k] = 1'b0;
               end
            end
            if (matched) begin
               r.status = ST_MATCHED;
               phase = PH_VALUE;
               value_count = '0;
            end else begin
               alive &= 4'((1 << n) - 1);
               if (alive == '0) begin
                  r.status = ST_NO_MATCH;
                  phase = PH_WAIT;
               end
               if (name_pos < 4'd15) name_pos++;
            end
         end else if (phase == PH_VALUE) begin
            if (b == NEWLINE_CHAR) begin
               r.status = ST_VALUE_DONE;
               r.value_length = value_count;
               phase = PH_WAIT;
            end else begin
               r.status = ST_VALUE_BYTE;
               r.value_byte = b;
               if (value_count != LENGTH_MAX) value_count++;
            end
         end
         expected_reports.push_back(r);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_report(logic [2:0] status, logic [1:0] key_index,
                                 logic [7:0] value_byte, logic [15:0] value_length);
         report_type r;
         if (expected_reports.size() == 0) begin
            $error("response with no request outstanding: status %0h", status);
            failures++;
            return;
         end
         r = expected_reports.pop_front();
         compare_field("status", 16'(r.status), 16'(status));
         compare_field("key_index", 16'(r.key_index), 16'(key_index));
         compare_field("value_byte", 16'(r.value_byte), 16'(value_byte));
         compare_field("value_length", r.value_length, value_length);
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [7:0]  req_byte_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_key_index;
   logic [7:0]  rsp_value_byte;
   logic [15:0] rsp_value_length;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_write_data = '0;

   field_match_tracker tracker = new();
   logic [63:0] cfg_word [NUM_KEYS];
   logic [15:0] cfg_lengths;
   logic [2:0]  cfg_count;
   bit          idle_on = 1'b1;
   int          sent = 0;
   int          quiet_cycles = 0;

   key_value_field_matcher_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_key_index    (rsp_key_index),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_value_length (rsp_value_length),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // response side: random stalls, check on every accepted response
   initial begin
      int stall;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         stall = idle_on ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         tracker.check_report(rsp_status, rsp_key_index, rsp_value_byte, rsp_value_length);
      end
   end

   task automatic send_request(input logic kind, input logic [7:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_byte_value <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      tracker.predict_byte(kind, value);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   task automatic configure();
      drain();
      for (int k = 0; k < NUM_KEYS; k++) write_csr(CSR_KEY_WORD_0 + 3'(k), cfg_word[k]);
      write_csr(CSR_KEY_LENGTHS, 64'(cfg_lengths));
      write_csr(CSR_KEY_COUNT, 64'(cfg_count));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int in_use;
      int shape;
      int k;
      int len;
      int cut;
      int next_reconfig;
      logic [7:0] b;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one key, zero-length name
      send_request(KIND_DATA, DELIM_CHAR);
      send_request(KIND_DATA, 8'h00);
      send_request(KIND_DATA, 8'hFF);
      send_request(KIND_DATA, NEWLINE_CHAR);
      send_request(KIND_DATA, 8'h55);
      send_request(KIND_END, 8'hFF);
      send_request(KIND_DATA, 8'h78);
      send_request(KIND_END, 8'h00);
      send_request(KIND_END, 8'h00);
      send_request(KIND_DATA, DELIM_CHAR);
      send_request(KIND_DATA, 8'h61);
      send_request(KIND_END, 8'h00);

      // all ones, lengths clamped, count above four
      foreach (cfg_word[i]) cfg_word[i] = '1;
      cfg_lengths = 16'hFFFF;
      cfg_count = 3'd7;
      configure();
      repeat (KEY_BYTES) send_request(KIND_DATA, 8'hFF);
      send_request(KIND_DATA, DELIM_CHAR);
      send_request(KIND_END, 8'h00);

      // no key in use
      foreach (cfg_word[i]) cfg_word[i] = '0;
      cfg_lengths = '0;
      cfg_count = 3'd0;
      configure();
      send_request(KIND_DATA, DELIM_CHAR);
      send_request(KIND_END, 8'h00);

      // key count lowered in the middle of a name
      cfg_word[0] = 64'h6261;
      cfg_word[1] = 64'h6361;
      cfg_lengths = 16'h0022;
      cfg_count = 3'd2;
      configure();
      send_request(KIND_DATA, 8'h61);
      cfg_count = 3'd1;
      configure();
      send_request(KIND_DATA, 8'h63);
      send_request(KIND_END, 8'h00);

      next_reconfig = sent;
      while (sent < RANDOM_ITEMS + 30) begin
         if (sent >= next_reconfig) begin
            idle_on = 1'b1;
            for (int i = 0; i < NUM_KEYS; i++) begin
               case ($urandom_range(0, 3))
                  0, 1: cfg_word[i] = {$urandom, $urandom};
                  2: cfg_word[i] = cfg_word[0];
                  default: for (int j = 0; j < 8; j++)
                     cfg_word[i][8*j +: 8] = 8'($urandom_range(8'h61, 8'h7A));
               endcase
               cfg_lengths[4*i +: 4] = ($urandom_range(0, 7) == 0) ?
                                       4'($urandom_range(9, 15)) :
                                       4'($urandom_range(0, 8));
            end
            cfg_count = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) :
                                                      3'($urandom_range(1, 4));
            configure();
            next_reconfig = sent + $urandom_range(50, 110);
         end
         idle_on = ($urandom_range(0, 4) != 0);
         in_use = (cfg_count > 3'd4) ? 4 : int'(cfg_count);
         shape = (in_use == 0) ? 8 : $urandom_range(0, 9);
         k = (in_use == 0) ? 0 : $urandom_range(0, in_use - 1);
         len = int'(cfg_lengths[4*k +: 4]);
         if (len > KEY_BYTES) len = KEY_BYTES;
         case (shape)
            7: begin
               cut = $urandom_range(0, len);
               for (int i = 0; i < cut; i++) send_request(KIND_DATA, cfg_word[k][8*i +: 8]);
               repeat ($urandom_range(1, 3)) send_request(KIND_DATA, 8'($urandom_range(0, 255)));
               send_request(KIND_END, 8'($urandom_range(0, 255)));
            end
            8: begin
               repeat ($urandom_range(1, 8)) begin
                  send_request(($urandom_range(0, 5) == 0) ? KIND_END : KIND_DATA,
                               8'($urandom_range(0, 255)));
               end
               send_request(KIND_END, 8'($urandom_range(0, 255)));
            end
            default: begin
               for (int i = 0; i < len; i++) send_request(KIND_DATA, cfg_word[k][8*i +: 8]);
               send_request(KIND_DATA, DELIM_CHAR);
               repeat ($urandom_range(0, 12)) begin
                  b = 8'($urandom_range(0, 255));
                  if (b == NEWLINE_CHAR) b = 8'h20;
                  send_request(KIND_DATA, b);
               end
               if (shape < 4 || shape == 9) send_request(KIND_DATA, NEWLINE_CHAR);
               if (shape == 9) begin
                  repeat (2) send_request(KIND_DATA, 8'($urandom_range(0, 255)));
                  send_request(KIND_END, 8'($urandom_range(0, 255)));
               end
               send_request(KIND_END, 8'($urandom_range(0, 255)));
            end
         endcase
      end

      idle_on = 1'b1;
      drain();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
